[hdl/dqhr_pkg.sv]
`default_nettype none

package dqhr_pkg;

	localparam int DQHR_DEPTH = 256;
	localparam int DQHR_WIDTH = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_ROTATE     = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push_front;
		logic    push_back;
		logic    pop_front;
		logic    pop_back;
		logic    rot_init;
		logic    rot_rd;
		logic    rot_wr;
		logic    res_load;
		status_t res_status;
		logic    res_from_ram;
	} dqhr_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic rot_skip;
		logic rot_last;
	} dqhr_sts_t;

endpackage

`default_nettype wire

[hdl/dqhr_req_if.sv]
`default_nettype none

interface dqhr_req_if import dqhr_pkg::*; ();
	logic               valid;
	logic               ready;
	opcode_t            opcode;
	logic signed [31:0] push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

`default_nettype wire

[hdl/dqhr_rsp_if.sv]
`default_nettype none

interface dqhr_rsp_if import dqhr_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [31:0] pop_value;

	modport source (output valid, output status, output pop_value, input ready);
	modport sink (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

[hdl/dqhr_ram.sv]
`default_nettype none

module dqhr_ram import dqhr_pkg::*; #(
	parameter int WIDTH = DQHR_WIDTH,
	parameter int DEPTH = DQHR_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/dqhr_dp.sv]
`default_nettype none

module dqhr_dp import dqhr_pkg::*; #(
	parameter int DEPTH = DQHR_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dqhr_cmd_t          cmd,
	output dqhr_sts_t               sts,
	input  wire logic signed [31:0] push_value,
	output status_t                 status,
	output logic signed [31:0]      pop_value
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] src_q;
	logic [IW-1:0] dst_q;
	logic [CW-1:0] rem_q;
	status_t       status_q;
	logic [31:0]   pop_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] src_inc;

	// a + b where the sum stays below twice the depth
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {{(CW + 1 - IW){1'b0}}, a} + {1'b0, b};
		if (s >= (CW + 1)'(DEPTH)) begin
			s = s - (CW + 1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign src_inc   = wrap_add(src_q, CW'(1));

	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(DEPTH));
	assign sts.rot_skip = (count_q < CW'(2));
	assign sts.rot_last = (rem_q == CW'(1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_dec;
		ram_wdata = push_value;
		ram_raddr = front_q;
		if (cmd.push_front) begin
			ram_we = 1'b1;
		end else if (cmd.push_back) begin
			ram_we    = 1'b1;
			ram_waddr = wrap_add(front_q, count_q);
		end else if (cmd.rot_wr) begin
			ram_we    = 1'b1;
			ram_waddr = dst_q;
			ram_wdata = ram_rdata;
		end
		if (cmd.pop_back) begin
			ram_raddr = wrap_add(front_q, count_q - CW'(1));
		end else if (cmd.rot_rd) begin
			ram_raddr = src_q;
		end
	end

	dqhr_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
				count_q <= count_q + CW'(1);
			end else if (cmd.push_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_front) begin
				front_q <= wrap_add(front_q, CW'(1));
				count_q <= count_q - CW'(1);
			end else if (cmd.pop_back) begin
				count_q <= count_q - CW'(1);
			end else if (cmd.rot_wr && sts.rot_last) begin
				// front moves past the copied half
				front_q <= src_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rot_init) begin
			src_q <= front_q;
			dst_q <= wrap_add(front_q, count_q);
			rem_q <= count_q >> 1;
		end else if (cmd.rot_wr) begin
			src_q <= src_inc;
			dst_q <= wrap_add(dst_q, CW'(1));
			rem_q <= rem_q - CW'(1);
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			pop_q    <= cmd.res_from_ram ? ram_rdata : '0;
		end
	end

	assign status    = status_q;
	assign pop_value = pop_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_back) |-> !sts.full)
		else $error("push issued on a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_front || cmd.pop_back) |-> !sts.empty)
		else $error("pop issued on an empty queue");

	a_rot_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rot_wr |=> $stable(count_q))
		else $error("rotate changed the entry count");

endmodule

`default_nettype wire

[hdl/dqhr_ctrl.sv]
`default_nettype none

module dqhr_ctrl import dqhr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dqhr_req_if.sink       req,
	dqhr_rsp_if.source     rsp,
	input  wire dqhr_sts_t sts,
	output dqhr_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_DATA,
		S_ROT_RD,
		S_ROT_WR
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   req_fire;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign rsp.valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					cmd.res_load = 1'b1;
					if (req.opcode inside {OP_PUSH_FRONT, OP_PUSH_BACK}) begin
						if (sts.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.push_front = (req.opcode == OP_PUSH_FRONT);
							cmd.push_back  = (req.opcode == OP_PUSH_BACK);
						end
					end else if (req.opcode inside {OP_POP_FRONT, OP_POP_BACK}) begin
						if (sts.empty) begin
							cmd.res_status = ST_EMPTY;
						end else begin
							// result comes once the store read returns
							cmd.res_load  = 1'b0;
							cmd.pop_front = (req.opcode == OP_POP_FRONT);
							cmd.pop_back  = (req.opcode == OP_POP_BACK);
							state_nxt     = S_POP_DATA;
						end
					end else if (req.opcode == OP_ROTATE && !sts.rot_skip) begin
						cmd.res_load = 1'b0;
						cmd.rot_init = 1'b1;
						state_nxt    = S_ROT_RD;
					end
				end
			end
			S_POP_DATA: begin
				cmd.res_load     = 1'b1;
				cmd.res_from_ram = 1'b1;
				state_nxt        = S_IDLE;
			end
			S_ROT_RD: begin
				cmd.rot_rd = 1'b1;
				state_nxt  = S_ROT_WR;
			end
			S_ROT_WR: begin
				cmd.rot_wr = 1'b1;
				if (sts.rot_last) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end else begin
					state_nxt = S_ROT_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten before taken");

	a_pop_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_DATA) |-> $past(req_fire))
		else $error("pop data phase without an accepted transaction");

	a_busy_no_result_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT_RD || state_q == S_ROT_WR || state_q == S_POP_DATA)
			|-> !out_valid_q)
		else $error("result pending while an operation is in flight");

endmodule

`default_nettype wire

[hdl/deque_with_half_rotation_core.sv]
// channel | dir | payload                          | handshake
// req     | in  | opcode[2:0], push_value[31:0]     | valid/ready
// rsp     | out | status[1:0], pop_value[31:0]      | valid/ready
//
// push, failed pop and no-op transactions: result registered at the accept edge
// pop: the store read is registered, then the pop data state loads the result register
// rotate: one store read then one write per moved entry, floor(count/2) entries moved
// a new request is taken once the controller is idle and the result register is free or being taken
// reset clears front index, count and control; store contents are left as they were
`default_nettype none

module deque_with_half_rotation_core import dqhr_pkg::*; #(
	parameter int DEPTH = DQHR_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dqhr_req_if.sink   req,
	dqhr_rsp_if.source rsp
);

	dqhr_cmd_t          cmd;
	dqhr_sts_t          sts;
	status_t            dp_status;
	logic signed [31:0] dp_pop_value;

	dqhr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.sts   (sts),
		.cmd   (cmd)
	);

	dqhr_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.push_value(req.push_value),
		.status    (dp_status),
		.pop_value (dp_pop_value)
	);

	assign rsp.status    = dp_status;
	assign rsp.pop_value = dp_pop_value;

endmodule

`default_nettype wire
